// File: rtl/core/checksummed_packet_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// Checksummed packet deframer - assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define CHECKSUMMED_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define CPDF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define CPDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that stays live through reset
`define CPDF_ASSERT_NEXT_LIVE(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cpdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpdf_pkg
// Types and constants shared by the checksummed packet deframer modules.
// ----------------------------------------------------------------------------
package cpdf_pkg;

    localparam int BUF_SIZE_DEF = 32;

    localparam logic [7:0] HDR_FIRST  = 8'h7E;
    localparam logic [7:0] HDR_SECOND = 8'h45;

    // payload bytes kept for decoding
    localparam int KEPT_BYTES = 13;
    localparam int KIDX_W     = $clog2(KEPT_BYTES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result item: 151 bits of fields, one pad bit
    localparam int OUT_W = 152;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_DIST_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_DIST_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BROADCAST   = 2'd2;

    // frame kinds
    localparam logic [1:0] KIND_DIST_FIRST  = 2'd0;
    localparam logic [1:0] KIND_DIST_SECOND = 2'd1;
    localparam logic [1:0] KIND_BROADCAST   = 2'd2;
    localparam logic [1:0] KIND_OTHER       = 2'd3;

    // checked frame handed from parser to decoder
    typedef struct packed {
        logic [KEPT_BYTES-1:0][7:0] payload;
        logic [7:0]                 length;
        logic [7:0]                 command;
    } frame_rec_t;

endpackage

// File: rtl/core/cpdf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpdf_front
// Byte parser: header hunt, length check, running sum, payload capture.
// ----------------------------------------------------------------------------
module cpdf_front import cpdf_pkg::*; #(
    parameter int BUF_SIZE = BUF_SIZE_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_accept,
    input  logic [7:0] rx_byte,
    output logic       rec_push,
    output frame_rec_t rec
);

    localparam int MaxLen = BUF_SIZE - 5;
    localparam int CntW   = $clog2(BUF_SIZE - 4);

    typedef enum logic [5:0] {
        ST_HUNT = 6'b000001,
        ST_HDR2 = 6'b000010,
        ST_CMD  = 6'b000100,
        ST_LEN  = 6'b001000,
        ST_PAY  = 6'b010000,
        ST_SUM  = 6'b100000
    } fstate_t;

    fstate_t                    state_reg, state_next;
    logic [CntW-1:0]            cnt_reg, cnt_next, len_reg, len_next, cnt_inc;
    logic [7:0]                 sum_reg, sum_next, cmd_reg, cmd_next, sum_add;
    logic [KEPT_BYTES-1:0][7:0] pay_reg, pay_next;
    logic                       len_ok;

    assign cnt_inc = cnt_reg + CntW'(1);
    assign sum_add = sum_reg + rx_byte;
    assign len_ok  = {1'b0, rx_byte} <= 9'(MaxLen);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        cmd_next   = cmd_reg;
        pay_next   = pay_reg;
        rec_push   = 1'b0;
        if (byte_accept) begin
            case (state_reg)
                ST_HUNT: begin
                    if (rx_byte == HDR_FIRST) begin
                        pay_next   = '0;
                        sum_next   = HDR_FIRST;
                        state_next = ST_HDR2;
                    end
                end
                ST_HDR2: begin
                    if (rx_byte == HDR_SECOND) begin
                        sum_next   = sum_add;
                        state_next = ST_CMD;
                    end else if (rx_byte == HDR_FIRST) begin
                        // a repeated first header restarts the frame
                        pay_next = '0;
                        sum_next = HDR_FIRST;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
                ST_CMD: begin
                    cmd_next   = rx_byte;
                    sum_next   = sum_add;
                    state_next = ST_LEN;
                end
                ST_LEN: begin
                    if (!len_ok) begin
                        state_next = ST_HUNT;
                    end else begin
                        len_next   = rx_byte[CntW-1:0];
                        sum_next   = sum_add;
                        cnt_next   = '0;
                        state_next = (rx_byte == 8'd0) ? ST_SUM : ST_PAY;
                    end
                end
                ST_PAY: begin
                    if (int'(cnt_reg) < KEPT_BYTES) begin
                        pay_next[cnt_reg[KIDX_W-1:0]] = rx_byte;
                    end
                    sum_next = sum_add;
                    cnt_next = cnt_inc;
                    if (cnt_inc == len_reg) begin
                        state_next = ST_SUM;
                    end
                end
                ST_SUM: begin
                    rec_push   = (rx_byte == sum_reg);
                    state_next = ST_HUNT;
                end
                default: begin
                    state_next = ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        len_reg <= len_next;
        sum_reg <= sum_next;
        cmd_reg <= cmd_next;
        pay_reg <= pay_next;
    end

    assign rec.command = cmd_reg;
    assign rec.length  = 8'(len_reg);
    assign rec.payload = pay_reg;

endmodule

// File: rtl/core/cpdf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpdf_queue
// Short frame queue between the parser and the decoder.
// ----------------------------------------------------------------------------
module cpdf_queue import cpdf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  frame_rec_t push_rec,
    output logic       full,
    output logic       head_valid,
    input  logic       pop,
    output frame_rec_t head_rec
);

    frame_rec_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_rec   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// File: rtl/core/cpdf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpdf_back
// Command code registers, kind decode and the result output register.
// ----------------------------------------------------------------------------
module cpdf_back import cpdf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 head_valid,
    input  frame_rec_t           head_rec,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata
);

    logic [7:0]       code_first_reg, code_second_reg, code_bcast_reg;
    logic             valid_reg;
    logic [OUT_W-1:0] data_reg;
    logic [1:0]       kind;
    logic [31:0]      value_word, pos_x_word, pos_y_word, ready_word;
    logic [KEPT_BYTES-1:0][7:0] p;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_first_reg  <= 8'd1;
            code_second_reg <= 8'd2;
            code_bcast_reg  <= 8'd3;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CODE_DIST_FIRST:  code_first_reg  <= cfg_data;
                CFG_CODE_DIST_SECOND: code_second_reg <= cfg_data;
                CFG_CODE_BROADCAST:   code_bcast_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // equal codes: first-beacon match wins, then second, then broadcast
    always_comb begin
        if (head_rec.command == code_first_reg) begin
            kind = KIND_DIST_FIRST;
        end else if (head_rec.command == code_second_reg) begin
            kind = KIND_DIST_SECOND;
        end else if (head_rec.command == code_bcast_reg) begin
            kind = KIND_BROADCAST;
        end else begin
            kind = KIND_OTHER;
        end
    end

    assign p          = head_rec.payload;
    assign value_word = {p[3], p[2], p[1], p[0]};
    assign pos_x_word = {p[4], p[3], p[2], p[1]};
    assign pos_y_word = {p[8], p[7], p[6], p[5]};
    assign ready_word = {p[12], p[11], p[10], p[9]};

    assign pop = head_valid && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (pop) begin
            data_reg <= {1'b0, ready_word, pos_y_word, pos_x_word, p[0], value_word,
                         head_rec.length[4:0], head_rec.command, kind};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// File: rtl/core/checksummed_packet_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_packet_deframer_unit
// Frame receiver: 0x7E 0x45 header, command, length, payload, 8-bit sum.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while s_tready is high, and emits one
// result item for each frame whose checksum byte matches the sum of all
// earlier frame bytes. The parser state machine handles one accepted byte
// per clock; checked frames pass through a two-entry queue to the decoder
// and its output register, so s_tready falls only when two checked frames
// are waiting behind a stalled result. m_tvalid rises after a frame clears
// the queue and output register. Lengths above BUF_SIZE-5 drop the frame.
module checksummed_packet_deframer_unit import cpdf_pkg::*; #(
    parameter int BUF_SIZE = BUF_SIZE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // tdata: rx_byte[7:0]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    // tdata: frame_kind[1:0], command_code[9:2], payload_length[14:10],
    //        value_word[46:15], node_number[54:47], pos_x_word[86:55],
    //        pos_y_word[118:87], ready_word[150:119], zero pad[151]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    logic       q_full, q_head_valid, q_pop, rec_push, byte_accept;
    frame_rec_t rec, head_rec;

    assign s_tready    = !q_full;
    assign byte_accept = s_tvalid && s_tready;

    cpdf_front #(
        .BUF_SIZE(BUF_SIZE)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_accept(byte_accept),
        .rx_byte    (s_tdata),
        .rec_push   (rec_push),
        .rec        (rec)
    );

    cpdf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_rec  (rec),
        .full      (q_full),
        .head_valid(q_head_valid),
        .pop       (q_pop),
        .head_rec  (head_rec)
    );

    cpdf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head_valid(q_head_valid),
        .head_rec  (head_rec),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/core/cpdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpdf_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "checksummed_packet_deframer_unit_defines.svh"

module cpdf_checker import cpdf_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_W-1:0]     m_tdata
);

    // a stalled result holds
    `CPDF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // reset empties queue and output register
    `CPDF_ASSERT_NEXT_LIVE(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready, "not empty after reset")

    // node number and the low bytes of pos_x overlay value_word
    `CPDF_ASSERT_SAME(a_overlay, aclk, aresetn, m_tvalid, (m_tdata[54:47] == m_tdata[22:15]) && (m_tdata[78:55] == m_tdata[46:23]), "payload decode mismatch")

endmodule

bind checksummed_packet_deframer_unit cpdf_checker u_cpdf_checker (.*);
